// ===== hw/rtl/xpt_pkg.sv =====
// ----------------------------------------------------------------------------
// xpt_pkg : shared definitions for the XNOR-popcount threshold engine
// Word geometry, register indexes, default limits and the popcount helper.
// ----------------------------------------------------------------------------
package xpt_pkg;

  localparam int WORD_BITS           = 32;
  localparam int WORD_LSB            = 5;     // log2 of the word size
  localparam int DEF_MAX_KERNEL_BITS = 4096;
  localparam int DEF_MAX_CHANNELS    = 1024;

  localparam int KB_W   = 13;                 // kernel_bits register width
  localparam int CO_R_W = 11;                 // channels_out register width
  localparam int CFG_W  = 13;                 // widest register
  localparam int IDX_W  = 2;
  localparam int THR_W  = 16;
  localparam int USED_W = 6;
  localparam int PC_W   = 6;

  localparam logic [IDX_W-1:0] CFG_KERNEL_BITS  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_CHANNELS_OUT = 2'd1;

  localparam logic [KB_W-1:0]   KB_RESET = 13'd32;
  localparam logic [CO_R_W-1:0] CO_RESET = 11'd32;

  // Filter-end decisions handed from the lanes to the packer
  typedef struct packed {
    logic take;
    logic hit_t0;
    logic hit_t1;
  } xpt_dec_t;

  // adder tree, five levels deep
  function automatic logic [PC_W-1:0] popcount32(input logic [WORD_BITS-1:0] x);
    logic [1:0] s2 [16];
    logic [2:0] s4 [8];
    logic [3:0] s8 [4];
    logic [4:0] s16 [2];
    for (int i = 0; i < 16; i++) begin
      s2[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
    end
    return {1'b0, s16[0]} + {1'b0, s16[1]};
  endfunction

endpackage

// ===== hw/rtl/xpt_lane.sv =====
// ----------------------------------------------------------------------------
// xpt_lane : one time-step lane
// XNOR against the weight word, masked popcount, running sum and threshold.
// ----------------------------------------------------------------------------
module xpt_lane #(
  parameter int MAX_KERNEL_BITS = xpt_pkg::DEF_MAX_KERNEL_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 last_word,
  input  logic [xpt_pkg::WORD_BITS-1:0]        mask,
  input  logic [xpt_pkg::WORD_BITS-1:0]        act,
  input  logic [xpt_pkg::WORD_BITS-1:0]        weight,
  input  logic signed [xpt_pkg::THR_W-1:0]     threshold,
  output logic                                 hit
);
  import xpt_pkg::*;

  localparam int SUM_W = $clog2(MAX_KERNEL_BITS + 1);
  localparam int CMP_W = (SUM_W + 1 > THR_W + 1) ? SUM_W + 1 : THR_W + 1;

  logic [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]        sum_next;
  logic [PC_W-1:0]         pc;
  logic signed [CMP_W-1:0] lhs;
  logic signed [CMP_W-1:0] rhs;

  assign pc       = popcount32(~(act ^ weight) & mask);
  assign sum_next = sum + SUM_W'(pc);
  assign lhs      = $signed(CMP_W'(sum_next));
  assign rhs      = CMP_W'(threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (accept) begin
      sum <= last_word ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_word) begin
      hit <= (lhs >= rhs);
    end
  end

endmodule

// ===== hw/rtl/xpt_packer.sv =====
// ----------------------------------------------------------------------------
// xpt_packer : merge stage
// Packs the lanes' decision bits MSB first and holds the output register.
// ----------------------------------------------------------------------------
module xpt_packer #(
  parameter int MAX_CHANNELS = xpt_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  xpt_pkg::xpt_dec_t                      dec,
  input  logic [$clog2(MAX_CHANNELS + 1)-1:0]    co_eff,
  input  logic                                   out_ready,
  output logic                                   space,
  output logic                                   out_valid,
  output logic [xpt_pkg::WORD_BITS-1:0]          out_t0,
  output logic [xpt_pkg::WORD_BITS-1:0]          out_t1,
  output logic [xpt_pkg::USED_W-1:0]             out_used,
  output logic                                   out_end
);
  import xpt_pkg::*;

  localparam int CO_W = $clog2(MAX_CHANNELS + 1);

  logic [WORD_BITS-1:0] pack_t0;
  logic [WORD_BITS-1:0] pack_t1;
  logic [USED_W-1:0]    fill;
  logic [CO_W-1:0]      chan;

  logic [WORD_BITS-1:0] pack_t0_next;
  logic [WORD_BITS-1:0] pack_t1_next;
  logic [USED_W-1:0]    fill_next;
  logic [CO_W-1:0]      chan_next;
  logic [WORD_LSB-1:0]  pos;
  logic                 done;
  logic                 emit;

  assign space = !out_valid || out_ready;

  always_comb begin
    pos          = WORD_LSB'(WORD_BITS - 1) - fill[WORD_LSB-1:0];
    pack_t0_next = pack_t0 | (WORD_BITS'(dec.hit_t0) << pos);
    pack_t1_next = pack_t1 | (WORD_BITS'(dec.hit_t1) << pos);
    fill_next    = fill + USED_W'(1);
    chan_next    = chan + CO_W'(1);
    done         = (chan_next >= co_eff);
    emit         = (fill_next == USED_W'(WORD_BITS)) || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_t0   <= '0;
      pack_t1   <= '0;
      fill      <= '0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (dec.take) begin
        if (emit) begin
          pack_t0   <= '0;
          pack_t1   <= '0;
          fill      <= '0;
          chan      <= done ? '0 : chan_next;
          out_valid <= 1'b1;
        end else begin
          pack_t0 <= pack_t0_next;
          pack_t1 <= pack_t1_next;
          fill    <= fill_next;
          chan    <= chan_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec.take && emit) begin
      out_t0   <= pack_t0_next;
      out_t1   <= pack_t1_next;
      out_used <= fill_next;
      out_end  <= done;
    end
  end

endmodule

// ===== hw/rtl/xnor_popcount_threshold_engine.sv =====
// ----------------------------------------------------------------------------
// xnor_popcount_threshold_engine : binary layer engine, top level
// Two time-step lanes accumulate XNOR popcounts per filter; the packer
// gathers the threshold decisions into 32-bit output words.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_t*): one item per weight word of the current filter,
//    with the two aligned activation words and the filter's threshold.
//    A filter spans ceil(kernel_bits/32) items; only the last one's
//    threshold is used.
//  - Output stream (m_t*): one item whenever 32 channel decisions have
//    been packed or the layer's last channel is done (then tlast is set).
//  - Config port: cfg_we/cfg_index/cfg_data, write only, taken on any edge
//    with cfg_we high; index 0 is kernel_bits, 1 is channels_out, others
//    are dropped. Write only while the block is idle.
// Timing: one input item per cycle sustained while s_tready stays high. The
// lanes' popcount, sum and threshold compare finish in the cycle of
// acceptance; the decision is registered, then packed and loaded into the
// output register that drives m_tvalid once the packer has space.
// Stalls: while m_tready is low a held result blocks only the decision
// stage; s_tready drops once that stage is also occupied.
// Reset (rst, synchronous): clears sums, counters and packing state and
// sets kernel_bits = 32, channels_out = 32.
// ----------------------------------------------------------------------------
module xnor_popcount_threshold_engine #(
  parameter int MAX_KERNEL_BITS = xpt_pkg::DEF_MAX_KERNEL_BITS,
  parameter int MAX_CHANNELS    = xpt_pkg::DEF_MAX_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [111:0]                s_tdata,  // act_t0, act_t1, weight_word, threshold
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [71:0]                 m_tdata,  // packed_t0, packed_t1, bits_used, zero pad
  output logic                        m_tlast,  // layer_end
  // configuration
  input  logic                        cfg_we,
  input  logic [xpt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [xpt_pkg::CFG_W-1:0]   cfg_data
);
  import xpt_pkg::*;

  localparam int WORDS_MAX = (MAX_KERNEL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W      = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int CO_W      = $clog2(MAX_CHANNELS + 1);

  // configuration registers
  logic [KB_W-1:0]   kernel_bits;
  logic [CO_R_W-1:0] channels_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_bits  <= KB_RESET;
      channels_out <= CO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_BITS:  kernel_bits  <= cfg_data;
        CFG_CHANNELS_OUT: channels_out <= CO_R_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // clamp to the supported range
  logic [31:0]          kb_eff;
  logic [31:0]          co_wide;
  logic [31:0]          last_idx;
  logic [WORD_BITS-1:0] mask;

  always_comb begin
    kb_eff = 32'(kernel_bits);
    if (kb_eff == 32'd0) begin
      kb_eff = 32'd1;
    end else if (kb_eff > 32'(MAX_KERNEL_BITS)) begin
      kb_eff = 32'(MAX_KERNEL_BITS);
    end
    co_wide = 32'(channels_out);
    if (co_wide == 32'd0) begin
      co_wide = 32'd1;
    end else if (co_wide > 32'(MAX_CHANNELS)) begin
      co_wide = 32'(MAX_CHANNELS);
    end
    last_idx = (kb_eff - 32'd1) >> WORD_LSB;
  end

  // filter sequencing
  logic [WI_W-1:0] word_index;
  logic            accept;
  logic            last_word;

  assign accept    = s_tvalid && s_tready;
  assign last_word = (32'(word_index) >= last_idx);

  // only the top (kernel_bits mod 32) bits of a filter's last word count
  always_comb begin
    mask = '1;
    if (last_word && (kb_eff[WORD_LSB-1:0] != '0)) begin
      mask = ~({WORD_BITS{1'b1}} >> kb_eff[WORD_LSB-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
    end else if (accept) begin
      word_index <= last_word ? '0 : word_index + WI_W'(1);
    end
  end

  // lanes, one per time step
  logic hit_t0;
  logic hit_t1;

  xpt_lane #(.MAX_KERNEL_BITS(MAX_KERNEL_BITS)) u_lane_t0 (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last_word (last_word),
    .mask      (mask),
    .act       (s_tdata[31:0]),
    .weight    (s_tdata[95:64]),
    .threshold ($signed(s_tdata[111:96])),
    .hit       (hit_t0)
  );

  xpt_lane #(.MAX_KERNEL_BITS(MAX_KERNEL_BITS)) u_lane_t1 (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .last_word (last_word),
    .mask      (mask),
    .act       (s_tdata[63:32]),
    .weight    (s_tdata[95:64]),
    .threshold ($signed(s_tdata[111:96])),
    .hit       (hit_t1)
  );

  // decision stage: valid only for filter-ending items
  logic     s1_valid;
  logic     space;
  logic     s2_take;
  xpt_dec_t dec;

  assign s2_take  = s1_valid && space;
  assign s_tready = !s1_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= last_word;
    end else if (s2_take) begin
      s1_valid <= 1'b0;
    end
  end

  assign dec.take   = s2_take;
  assign dec.hit_t0 = hit_t0;
  assign dec.hit_t1 = hit_t1;

  // merge stage
  logic [WORD_BITS-1:0] packed_t0;
  logic [WORD_BITS-1:0] packed_t1;
  logic [USED_W-1:0]    bits_used;

  xpt_packer #(.MAX_CHANNELS(MAX_CHANNELS)) u_packer (
    .clk       (clk),
    .rst       (rst),
    .dec       (dec),
    .co_eff    (CO_W'(co_wide)),
    .out_ready (m_tready),
    .space     (space),
    .out_valid (m_tvalid),
    .out_t0    (packed_t0),
    .out_t1    (packed_t1),
    .out_used  (bits_used),
    .out_end   (m_tlast)
  );

  assign m_tdata = {2'b00, bits_used, packed_t1, packed_t0};

  // checks
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (bits_used != '0) && (bits_used <= USED_W'(WORD_BITS)))
    else $error("bits_used out of range");

  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (bits_used < USED_W'(WORD_BITS)) |->
      ((packed_t0 << bits_used) == '0) && ((packed_t1 << bits_used) == '0))
    else $error("bits below bits_used not zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> s1_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s2_take))
    else $error("result appeared without a packed decision");

endmodule
